### sv/pressure_grid_baseline_corrector_macros.svh
// Assertion macros for the pressure grid baseline corrector.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef PRESSURE_GRID_BASELINE_CORRECTOR_MACROS_SVH
`define PRESSURE_GRID_BASELINE_CORRECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define PGBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PGBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PGBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define PGBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/pgbc_pkg.sv
// Shared widths, codes and beat structures for the pressure grid baseline corrector.
// No dependencies; imported by every module of the block.
package pgbc_pkg;

  localparam int ROW_W     = 4;
  localparam int COL_W     = 5;
  localparam int SAMP_W    = 24;
  localparam int PRESS_W   = 16;
  localparam int STORE_W   = 26;
  localparam int FRAME_W   = 32;
  localparam int SHIFT_W   = 5;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  // Stream payload layout
  localparam int IN_TDATA_W  = 40;
  localparam int IN_PAD_W    = IN_TDATA_W - (ROW_W + COL_W + SAMP_W + 2);
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (ROW_W + COL_W + PRESS_W + FRAME_W);

  typedef enum logic {
    REQ_CAL  = 1'b0,
    REQ_MEAS = 1'b1
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SCALE  = 2'd0,
    CFG_NOISE_THR   = 2'd1,
    CFG_SCALE_SHIFT = 2'd2
  } cfg_e;

  // Decoded input beat
  typedef struct packed {
    req_e               req;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [SAMP_W-1:0]  sample;
    logic               first_pass;
    logic               last_pass;
  } in_beat_t;

  // Result handed from the pipeline to the output stage
  typedef struct packed {
    logic [ROW_W-1:0]   cell_row;
    logic [COL_W-1:0]   cell_col;
    logic [PRESS_W-1:0] pressure;
    logic               used_baseline;
    logic               frame_end;
  } res_t;

endpackage

### sv/pressure_grid_baseline_corrector.sv
// Pressure grid baseline corrector: config registers, baseline memory, RMW pipeline, output.
// Latency: a result passes through stages A, B and C and the output register before it is on m_axis.
// Throughput: one beat per cycle while m_axis is not stalled; a beat whose cell has a calibration write
// still in the three pipeline stages waits until that write has left stage C.
// Reset: asynchronous, active low; clears flags and frame count, loads config defaults.
module pressure_grid_baseline_corrector import pgbc_pkg::*; #(
  parameter int ROWS        = 16,
  parameter int COLS        = 32,
  parameter int CAL_PASSES  = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: row, col, sample, first_pass, last_pass, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: req_type
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: cell_row, cell_col, pressure, frames_done, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: used_baseline
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  localparam int DEPTH    = ROWS * COLS;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SAMP_EFF = (SAMPLE_BITS < SAMP_W) ? SAMPLE_BITS : SAMP_W;
  localparam logic [SAMP_W-1:0] SAMP_MASK = SAMP_W'((64'd1 << SAMP_EFF) - 64'd1);

  logic [CFG_W-1:0]   full_scale_q;
  logic [CFG_W-1:0]   noise_thr_q;
  logic [SHIFT_W-1:0] scale_shift_q;

  in_beat_t           in_beat;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [STORE_W-1:0] rd_data, wr_data;
  logic               res_valid, res_ready;
  res_t               res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q  <= '1;
      noise_thr_q   <= '0;
      scale_shift_q <= SHIFT_W'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_FULL_SCALE:  full_scale_q  <= cfg_wdata_i;
        CFG_NOISE_THR:   noise_thr_q   <= cfg_wdata_i;
        CFG_SCALE_SHIFT: scale_shift_q <= cfg_wdata_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input beat, keep the converter's significant bits
  always_comb begin
    in_beat.req        = req_e'(s_axis_tuser);
    in_beat.row        = s_axis_tdata[ROW_W-1:0];
    in_beat.col        = s_axis_tdata[ROW_W +: COL_W];
    in_beat.sample     = s_axis_tdata[ROW_W + COL_W +: SAMP_W] & SAMP_MASK;
    in_beat.first_pass = s_axis_tdata[ROW_W + COL_W + SAMP_W];
    in_beat.last_pass  = s_axis_tdata[ROW_W + COL_W + SAMP_W + 1];
  end

  pgbc_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  pgbc_pipe #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .CAL_PASSES (CAL_PASSES),
    .AW         (AW)
  ) u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_beat_i     (in_beat),
    .in_ready_o    (s_axis_tready),
    .full_scale_i  (full_scale_q),
    .noise_thr_i   (noise_thr_q),
    .scale_shift_i (scale_shift_q),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  pgbc_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .res_ready_o   (res_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### sv/pgbc_ram.sv
// Per-cell baseline memory: one write port, one read port with registered read data.
// Depends on pgbc_pkg for the entry width.
module pgbc_ram import pgbc_pkg::*; #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [STORE_W-1:0] rd_data_o,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [STORE_W-1:0] wr_data_i
);

  logic [STORE_W-1:0] mem_q [DEPTH];
  logic [STORE_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/pgbc_out.sv
// Output register stage and frame counter for the pressure grid baseline corrector.
// Depends on pgbc_pkg for the result structure and payload layout.
module pgbc_out import pgbc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   res_valid_i,
  input  res_t                   res_i,
  output logic                   res_ready_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: cell_row, cell_col, pressure, frames_done, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: used_baseline
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  logic               out_valid_q;
  res_t               out_res_q;
  logic [FRAME_W-1:0] out_frames_q;
  logic [FRAME_W-1:0] frame_cnt_q;
  logic [FRAME_W-1:0] frame_cnt_d;
  logic               load;

  assign res_ready_o = !out_valid_q || m_axis_tready;
  assign load        = res_valid_i && res_ready_o;
  assign frame_cnt_d = frame_cnt_q + FRAME_W'(res_i.frame_end);

  // Control: output valid and frame count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      frame_cnt_q <= '0;
    end else begin
      if (res_ready_o) begin
        out_valid_q <= res_valid_i;
      end
      if (load) begin
        frame_cnt_q <= frame_cnt_d;
      end
    end
  end

  // Payload: capture result with the count that includes it
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_res_q    <= res_i;
      out_frames_q <= frame_cnt_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_frames_q, out_res_q.pressure,
                          out_res_q.cell_col, out_res_q.cell_row};
  assign m_axis_tuser  = out_res_q.used_baseline;
  assign m_axis_tlast  = out_res_q.frame_end;

endmodule

### sv/pgbc_pipe.sv
// Three-stage read-modify-write pipeline around the baseline memory.
// Depends on pgbc_pkg and the assertion macros header.
`include "pressure_grid_baseline_corrector_macros.svh"

module pgbc_pipe import pgbc_pkg::*; #(
  parameter int ROWS       = 16,
  parameter int COLS       = 32,
  parameter int CAL_PASSES = 4,
  parameter int AW         = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  in_beat_t           in_beat_i,
  output logic               in_ready_o,
  input  logic [CFG_W-1:0]   full_scale_i,
  input  logic [CFG_W-1:0]   noise_thr_i,
  input  logic [SHIFT_W-1:0] scale_shift_i,
  output logic               rd_en_o,
  output logic [AW-1:0]      rd_addr_o,
  input  logic [STORE_W-1:0] rd_data_i,
  output logic               wr_en_o,
  output logic [AW-1:0]      wr_addr_o,
  output logic [STORE_W-1:0] wr_data_o,
  output logic               res_valid_o,
  output res_t               res_o,
  input  logic               res_ready_i
);

  // Divide by the pass count as multiply by reciprocal, exact for 26-bit sums
  localparam int          DIV_L   = $clog2(CAL_PASSES);
  localparam int          DIV_S   = STORE_W + DIV_L;
  localparam int          MULT_W  = STORE_W + 1;
  localparam int          PROD_W  = STORE_W + MULT_W;
  localparam logic [63:0] DIV_M64 = ((64'd1 << DIV_S) + 64'(CAL_PASSES) - 64'd1) /
                                    64'(CAL_PASSES);
  localparam logic [MULT_W-1:0] DIV_M = DIV_M64[MULT_W-1:0];

  // Input decode
  logic          in_range;
  logic          in_final;
  logic [AW-1:0] in_idx;
  logic          accept;
  logic          hazard;

  // Stage A: beat with memory read data
  logic               a_valid_q, a_cal_q, a_first_q, a_last_q, a_final_q;
  logic [AW-1:0]      a_idx_q;
  logic [ROW_W-1:0]   a_row_q;
  logic [COL_W-1:0]   a_col_q;
  logic [SAMP_W-1:0]  a_samp_q;

  // Stage B: sum or raw pressure
  logic               b_valid_q, b_cal_q, b_last_q, b_final_q, b_used_q;
  logic [AW-1:0]      b_idx_q;
  logic [ROW_W-1:0]   b_row_q;
  logic [COL_W-1:0]   b_col_q;
  logic [STORE_W-1:0] b_val_q;

  // Stage C: product, final pressure, write-back
  logic               c_valid_q, c_cal_q, c_last_q, c_final_q, c_used_q;
  logic [AW-1:0]      c_idx_q;
  logic [ROW_W-1:0]   c_row_q;
  logic [COL_W-1:0]   c_col_q;
  logic [STORE_W-1:0] c_val_q;
  logic [PROD_W-1:0]  c_prod_q;
  logic [PRESS_W-1:0] c_press_q;

  logic calibrated_q;
  logic calibrated_d;

  logic a_rdy, a_adv, b_rdy, b_adv, c_rdy, c_adv;
  logic b_set, c_set, cal_eff;
  logic [STORE_W-1:0] samp_ext, sum, meas_p, b_val_d;
  logic [STORE_W-1:0] p_thr;
  logic [PROD_W-1:0]  prod;
  logic [PRESS_W-1:0] press;

  // Decode cell position
  assign in_range = (32'(in_beat_i.row) < ROWS) && (32'(in_beat_i.col) < COLS);
  assign in_final = (32'(in_beat_i.row) == ROWS - 1) && (32'(in_beat_i.col) == COLS - 1);
  assign in_idx   = AW'(32'(in_beat_i.row) * COLS + 32'(in_beat_i.col));

  // Interlock: hold a beat whose cell has a calibration write still in flight
  assign hazard = in_range &&
                  ((a_valid_q && a_cal_q && (a_idx_q == in_idx)) ||
                   (b_valid_q && b_cal_q && (b_idx_q == in_idx)) ||
                   (c_valid_q && c_cal_q && (c_idx_q == in_idx)));

  // Stage flow: calibration leaves C at once, measurement waits for the output slot
  assign c_adv = c_valid_q && (c_cal_q || res_ready_i);
  assign c_rdy = !c_valid_q || c_adv;
  assign b_adv = b_valid_q && c_rdy;
  assign b_rdy = !b_valid_q || c_rdy;
  assign a_adv = a_valid_q && b_rdy;
  assign a_rdy = !a_valid_q || b_rdy;

  assign in_ready_o = a_rdy && !hazard;
  assign accept     = in_valid_i && in_ready_o;

  assign rd_en_o   = accept && in_range;
  assign rd_addr_o = in_idx;

  // Calibrated flag as seen by a measurement in stage A
  assign b_set   = b_valid_q && b_cal_q && b_last_q && b_final_q;
  assign c_set   = c_valid_q && c_cal_q && c_last_q && c_final_q;
  assign cal_eff = calibrated_q || b_set || c_set;
  assign calibrated_d = calibrated_q || c_set;

  // Stage A work: accumulate or correct
  always_comb begin
    samp_ext = STORE_W'(a_samp_q);
    sum      = a_first_q ? samp_ext : (rd_data_i + samp_ext);
    if (cal_eff) begin
      meas_p = (rd_data_i > samp_ext) ? (rd_data_i - samp_ext) : '0;
    end else begin
      meas_p = (a_samp_q < full_scale_i) ? STORE_W'(full_scale_i - a_samp_q) : '0;
    end
    b_val_d = a_cal_q ? sum : meas_p;
  end

  // Stage B work: reciprocal multiply, threshold and scale
  assign prod  = PROD_W'(b_val_q) * PROD_W'(DIV_M);
  assign p_thr = (b_val_q < STORE_W'(noise_thr_i)) ? '0 : b_val_q;
  assign press = PRESS_W'(p_thr >> scale_shift_i);

  // Stage C: write back the baseline, hand off the result
  assign wr_en_o   = c_valid_q && c_cal_q;
  assign wr_addr_o = c_idx_q;
  assign wr_data_o = c_last_q ? STORE_W'(c_prod_q >> DIV_S) : c_val_q;

  assign res_valid_o = c_valid_q && !c_cal_q;
  always_comb begin
    res_o.cell_row      = c_row_q;
    res_o.cell_col      = c_col_q;
    res_o.pressure      = c_press_q;
    res_o.used_baseline = c_used_q;
    res_o.frame_end     = c_final_q;
  end

  // Control: stage valids and calibrated flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      b_valid_q    <= 1'b0;
      c_valid_q    <= 1'b0;
      calibrated_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_valid_q <= accept && in_range;
      end
      if (b_rdy) begin
        b_valid_q <= a_valid_q;
      end
      if (c_rdy) begin
        c_valid_q <= b_valid_q;
      end
      calibrated_q <= calibrated_d;
    end
  end

  // Payload: advance stage contents
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_cal_q   <= (in_beat_i.req == REQ_CAL);
      a_idx_q   <= in_idx;
      a_row_q   <= in_beat_i.row;
      a_col_q   <= in_beat_i.col;
      a_samp_q  <= in_beat_i.sample;
      a_first_q <= in_beat_i.first_pass;
      a_last_q  <= in_beat_i.last_pass;
      a_final_q <= in_final;
    end
    if (a_adv) begin
      b_cal_q   <= a_cal_q;
      b_idx_q   <= a_idx_q;
      b_row_q   <= a_row_q;
      b_col_q   <= a_col_q;
      b_last_q  <= a_last_q;
      b_final_q <= a_final_q;
      b_val_q   <= b_val_d;
      b_used_q  <= cal_eff;
    end
    if (b_adv) begin
      c_cal_q   <= b_cal_q;
      c_idx_q   <= b_idx_q;
      c_row_q   <= b_row_q;
      c_col_q   <= b_col_q;
      c_last_q  <= b_last_q;
      c_final_q <= b_final_q;
      c_val_q   <= b_val_q;
      c_prod_q  <= prod;
      c_press_q <= press;
      c_used_q  <= b_used_q;
    end
  end

  `PGBC_ASSERT_IMPL(a_no_rw_clash, clk_i, rst_ni, wr_en_o && rd_en_o, wr_addr_o != rd_addr_o, "read of a cell being written")
  `PGBC_ASSERT_IMPL(a_bc_distinct, clk_i, rst_ni, b_valid_q && b_cal_q && c_valid_q && c_cal_q, b_idx_q != c_idx_q, "two writes in flight to one cell")
  `PGBC_ASSERT_NEXT(a_cal_sticky, clk_i, rst_ni, calibrated_q, calibrated_q, "calibrated flag dropped")
  `PGBC_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_o && !res_ready_i, res_valid_o && $stable(res_o), "stalled result lost or changed")

endmodule

### tb/pressure_grid_baseline_corrector_tb.sv
// Self-checking testbench for pressure_grid_baseline_corrector: a stream driver, a result
// monitor and a cycle-free predictor of the per-cell baseline and pressure values.
// Depends on pgbc_pkg and the pressure_grid_baseline_corrector RTL only.
module pressure_grid_baseline_corrector_tb;
  import pgbc_pkg::*;

  localparam int ROWS       = 16;
  localparam int COLS       = 32;
  localparam int CAL_PASSES = 4;
  localparam int CELL_W     = ROW_W + COL_W;
  localparam logic [CELL_W-1:0] LAST_CELL = {4'(ROWS - 1), 5'(COLS - 1)};

  // Output tdata field offsets, lowest bit up
  localparam int O_COL   = ROW_W;
  localparam int O_PRESS = O_COL + COL_W;
  localparam int O_FRAME = O_PRESS + PRESS_W;

  typedef struct packed {
    logic [ROW_W-1:0]   cell_row;
    logic [COL_W-1:0]   cell_col;
    logic [PRESS_W-1:0] pressure;
    logic               used_baseline;
    logic               frame_end;
    logic [FRAME_W-1:0] frames_done;
  } cell_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = CFG_FULL_SCALE;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;

  pressure_grid_baseline_corrector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Predictor state: mirrored registers, baseline memory, flag and frame counter
  logic [SAMP_W-1:0]  full_scale = 24'hFFFFFF;
  logic [SAMP_W-1:0]  noise_thr = '0;
  logic [SHIFT_W-1:0] press_shift = 5'd8;
  logic [STORE_W-1:0] baseline_mem [2**CELL_W];
  bit                 is_calibrated = 1'b0;
  logic [FRAME_W-1:0] frame_cnt = '0;

  cell_result_t pressure_q [$];
  in_beat_t     sample_q [$];
  int           beats_in_flight = 0;
  int           mismatches = 0;

  // Stimulus-side bookkeeping: which cells hold a baseline, and a rough level per cell
  bit                gen_written [2**CELL_W];
  bit [SAMP_W-1:0]   gen_level [2**CELL_W];
  bit                gen_cal = 1'b0;
  bit                allow_cal_done = 1'b0;
  bit                quiet = 1'b0;

  // Update the baseline or work out the pressure for one accepted beat
  function automatic void correct_cell(in_beat_t b);
    logic [CELL_W-1:0]  idx;
    logic [STORE_W-1:0] acc;
    logic [STORE_W-1:0] pr;
    cell_result_t       r;
    bit                 at_last;
    idx = {b.row, b.col};
    at_last = (idx == LAST_CELL);
    if (b.req == REQ_CAL) begin
      acc = b.first_pass ? STORE_W'(b.sample) : baseline_mem[idx] + STORE_W'(b.sample);
      if (b.last_pass) acc = STORE_W'(acc / CAL_PASSES);
      baseline_mem[idx] = acc;
      if (b.last_pass && at_last) is_calibrated = 1'b1;
    end else begin
      if (is_calibrated)
        pr = (baseline_mem[idx] > b.sample) ? baseline_mem[idx] - b.sample : '0;
      else
        pr = (full_scale > b.sample) ? STORE_W'(full_scale - b.sample) : '0;
      if (pr < noise_thr) pr = '0;
      pr = pr >> press_shift;
      if (at_last) frame_cnt++;
      r.cell_row      = b.row;
      r.cell_col      = b.col;
      r.pressure      = pr[PRESS_W-1:0];
      r.used_baseline = is_calibrated;
      r.frame_end     = at_last;
      r.frames_done   = frame_cnt;
      pressure_q.push_back(r);
    end
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int idle_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: present queued beats, predict each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin : driver
    in_beat_t cur;
    int       gap;
    bit       holding;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap = 0;
    end else begin
      holding = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        correct_cell(cur);
        beats_in_flight--;
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap > 0) begin
          gap--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          cur = sample_q.pop_front();
          s_axis_tdata <= {IN_PAD_W'(0), cur.last_pass, cur.first_pass, cur.sample,
                           cur.col, cur.row};
          s_axis_tuser <= cur.req;
          s_axis_tvalid <= 1'b1;
          gap = idle_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Monitor: compare each result beat with the oldest expectation, stall at random
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    cell_result_t want;
    int           stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pressure_q.size() == 0) begin
          $error("result beat with no expectation pending: tdata 0x%0h", m_axis_tdata);
          mismatches++;
        end else begin
          want = pressure_q.pop_front();
          check_field("cell_row", want.cell_row, m_axis_tdata[O_COL-1:0]);
          check_field("cell_col", want.cell_col, m_axis_tdata[O_PRESS-1:O_COL]);
          check_field("pressure", want.pressure, m_axis_tdata[O_FRAME-1:O_PRESS]);
          check_field("used_baseline", want.used_baseline, m_axis_tuser);
          check_field("frame_end", want.frame_end, m_axis_tlast);
          check_field("frames_done", want.frames_done,
                      m_axis_tdata[O_FRAME+FRAME_W-1:O_FRAME]);
        end
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 4) == 0) stall = idle_len();
      end
    end
  end

  // Queue one beat; keep calibration legal so no unwritten baseline is ever read
  function automatic void queue_beat(req_e rq, logic [CELL_W-1:0] c, logic [SAMP_W-1:0] smp,
                                     logic first, logic last);
    in_beat_t b;
    if (rq == REQ_CAL) begin
      if (!gen_written[c]) first = 1'b1;
      if (!allow_cal_done && c == LAST_CELL) last = 1'b0;
      gen_written[c] = 1'b1;
      gen_level[c] = smp;
      if (last && c == LAST_CELL) gen_cal = 1'b1;
    end
    b.req        = rq;
    b.row        = c[CELL_W-1:COL_W];
    b.col        = c[COL_W-1:0];
    b.sample     = smp;
    b.first_pass = first;
    b.last_pass  = last;
    sample_q.push_back(b);
    beats_in_flight++;
  endfunction

  // Sample close to a level, now and then anywhere in range
  function automatic logic [SAMP_W-1:0] near_level(logic [SAMP_W-1:0] lvl);
    int unsigned d;
    d = $urandom_range(0, 24'h3FFFF);
    if ($urandom_range(0, 3) == 0) return SAMP_W'($urandom);
    if ($urandom_range(0, 1)) return (lvl > d) ? lvl - SAMP_W'(d) : '0;
    return (24'hFFFFFF - lvl > d) ? lvl + SAMP_W'(d) : 24'hFFFFFF;
  endfunction

  // Measurement cell: the frame-closing cell often; once calibrated, only written cells
  function automatic logic [CELL_W-1:0] pick_meas_cell();
    logic [CELL_W-1:0] c;
    c = ($urandom_range(0, 7) == 0) ? LAST_CELL : CELL_W'($urandom);
    while (gen_cal && !gen_written[c]) c = CELL_W'($urandom);
    return c;
  endfunction

  // Random beats: mostly full calibration runs and measurements, some stray calibration
  task automatic run_phase(int count);
    int                n;
    int                k;
    int unsigned       sel;
    logic [CELL_W-1:0] c;
    logic [SAMP_W-1:0] lvl;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        c = ($urandom_range(0, 7) == 0) ? LAST_CELL : CELL_W'($urandom);
        lvl = SAMP_W'($urandom);
        for (k = 0; k < CAL_PASSES; k++)
          queue_beat(REQ_CAL, c, near_level(lvl), k == 0, k == CAL_PASSES - 1);
        n += CAL_PASSES;
        // measure the freshly calibrated cell right behind its last pass
        if ($urandom_range(0, 1)) begin
          queue_beat(REQ_MEAS, c, near_level(gen_level[c]), 1'($urandom), 1'($urandom));
          n++;
        end
      end else if (sel < 85) begin
        c = pick_meas_cell();
        queue_beat(REQ_MEAS, c,
                   $urandom_range(0, 1) ? near_level(gen_level[c]) : SAMP_W'($urandom),
                   1'($urandom), 1'($urandom));
        n++;
      end else begin
        queue_beat(REQ_CAL, CELL_W'($urandom), SAMP_W'($urandom), 1'($urandom), 1'($urandom));
        n++;
      end
    end
  endtask

  // Hold until every beat is taken and every result is back, then let the pipeline empty
  task automatic wait_idle();
    while (beats_in_flight != 0 || pressure_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write all three registers while the block is idle
  task automatic cfg_apply(logic [SAMP_W-1:0] fs, logic [SAMP_W-1:0] thr,
                           logic [SHIFT_W-1:0] sh);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_FULL_SCALE;
    cfg_wdata_i <= fs;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_NOISE_THR;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SCALE_SHIFT;
    cfg_wdata_i <= CFG_W'(sh);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    full_scale  = fs;
    noise_thr   = thr;
    press_shift = sh;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Inversion at reset settings: both sample extremes, frame-closing cell
    queue_beat(REQ_MEAS, {4'd0, 5'd0}, 24'h000000, 1'b0, 1'b0);
    queue_beat(REQ_MEAS, LAST_CELL, 24'hFFFFFF, 1'b1, 1'b1);
    queue_beat(REQ_MEAS, {4'd7, 5'd16}, 24'h123456, 1'b0, 1'b1);
    // First and last pass together; then a sum that wraps the baseline width
    queue_beat(REQ_CAL, {4'd0, 5'd0}, 24'hFFFFFF, 1'b1, 1'b1);
    queue_beat(REQ_CAL, {4'd1, 5'd1}, 24'hFFFFFF, 1'b1, 1'b0);
    repeat (5) queue_beat(REQ_CAL, {4'd1, 5'd1}, 24'hFFFFFF, 1'b0, 1'b0);
    queue_beat(REQ_CAL, {4'd1, 5'd1}, 24'hFFFFFF, 1'b0, 1'b1);
    wait_idle();

    // Uncalibrated phases across register extremes
    quiet = 1'b1;
    cfg_apply(24'hFFFFFF, 24'h000000, 5'd0);
    run_phase(200);
    wait_idle();
    quiet = 1'b0;
    cfg_apply(24'h000000, 24'hFFFFFF, 5'd24);
    run_phase(200);
    wait_idle();
    cfg_apply(SAMP_W'($urandom), SAMP_W'($urandom_range(0, 24'hFFFFF)),
              SHIFT_W'($urandom_range(0, 24)));
    run_phase(200);
    wait_idle();

    // Close calibration on the frame-closing cell, then baseline subtraction
    cfg_apply(24'h800000, 24'h000000, 5'd0);
    allow_cal_done = 1'b1;
    queue_beat(REQ_CAL, LAST_CELL, 24'h800000, 1'b1, 1'b0);
    queue_beat(REQ_CAL, LAST_CELL, 24'h800000, 1'b0, 1'b1);
    queue_beat(REQ_MEAS, LAST_CELL, 24'h3FFF00, 1'b0, 1'b0);
    queue_beat(REQ_MEAS, LAST_CELL, 24'hFFFFFF, 1'b0, 1'b0);
    queue_beat(REQ_MEAS, {4'd0, 5'd0}, 24'h3FFFFE, 1'b1, 1'b0);
    queue_beat(REQ_MEAS, {4'd1, 5'd1}, 24'h000000, 1'b0, 1'b1);
    // recalibration leaves the calibrated flag set
    queue_beat(REQ_CAL, {4'd0, 5'd0}, 24'h001000, 1'b1, 1'b0);
    queue_beat(REQ_MEAS, {4'd0, 5'd0}, 24'h000000, 1'b0, 1'b0);
    wait_idle();

    // Calibrated phases
    quiet = 1'b1;
    cfg_apply(SAMP_W'($urandom), 24'h000000, 5'd0);
    run_phase(210);
    wait_idle();
    quiet = 1'b0;
    cfg_apply(SAMP_W'($urandom), 24'hFFFFFF, 5'd24);
    run_phase(210);
    wait_idle();
    cfg_apply(SAMP_W'($urandom), SAMP_W'($urandom_range(0, 16'hFFFF)), 5'd4);
    run_phase(210);
    wait_idle();
    cfg_apply(SAMP_W'($urandom), SAMP_W'($urandom_range(0, 24'hFFFFF)),
              SHIFT_W'($urandom_range(0, 24)));
    run_phase(210);
    wait_idle();

    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/pgbc_pkg.sv
sv/pgbc_ram.sv
sv/pgbc_out.sv
sv/pgbc_pipe.sv
sv/pressure_grid_baseline_corrector.sv
tb/pressure_grid_baseline_corrector_tb.sv
